// ===== hdl/topk_pkg.sv =====
// Shared types and constants for the top-k nearest selector.
// Used by topk_cell and topk_nearest_selector_unit; depends on nothing.
`default_nettype none

package topk_pkg;

	localparam int MAX_KEEP = 16;
	localparam int DATA_W   = 32;
	localparam int CFG_W    = 5;
	localparam int FILL_W   = $clog2(MAX_KEEP + 1);

	localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(10);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [FILL_W-1:0] fill_t;

	// Operation broadcast to every cell of the chain in the same cycle.
	typedef enum logic [2:0] {
		OP_HOLD    = 3'd0,
		OP_ADD     = 3'd1,
		OP_REPLACE = 3'd2,
		OP_SHIFT   = 3'd3,
		OP_CLEAR   = 3'd4
	} cell_op_t;

	// What a cell shows to its neighbors.
	typedef struct packed {
		logic  valid;
		logic  ahead;
		data_t held_dist;
		data_t id;
	} link_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FLUSH = 2'b10
	} state_t;

	// True when pair (da, ia) orders after pair (db, ib).
	function automatic logic pair_after(data_t da, data_t ia, data_t db, data_t ib);
		logic r;
		if (da != db) begin
			r = (da > db);
		end else begin
			r = (ia > ib);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/topk_nearest_selector_unit.sv =====
// Top level of the top-k nearest selector: control, fill count, output register.
// Depends on topk_pkg and instantiates a row of topk_cell.
//
// Usage. A command beat is taken at a clock edge where start is high and busy
// is low. func 0 offers (distance, cand_id); func 1 flushes the kept ids.
// The cells hold the candidates sorted by (distance, id), so an offer is
// inserted, or replaces the worst entry if its distance is smaller, as it is
// accepted; offers can be issued every cycle while idle and produce no result.
// A flush shifts the chain toward cell 0, one entry per cycle, and emits
// min(held, k) result beats on consecutive cycles; busy is high during the
// flush, the first beat shows in the cycle after busy rises and the last one
// in the first cycle with busy low again. The last beat carries last.
// A flush of an empty store gives one beat with last and empty_res set in the
// cycle after the flush is taken, without raising busy. Each result beat shows
// on result_id, last and empty_res for one cycle while result_strobe is high;
// the receiver cannot hold it off. keep_count is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block does not enforce. 0 acts as 1 and values above the chain length act
// as the chain length. Reset empties the store and sets keep_count to 10.
`default_nettype none

module topk_nearest_selector_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire                           func,
	input  wire  [topk_pkg::DATA_W-1:0]   distance,
	input  wire  [topk_pkg::DATA_W-1:0]   cand_id,
	input  wire                           cfg_we,
	input  wire  [topk_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                          result_strobe,
	output logic [topk_pkg::DATA_W-1:0]   result_id,
	output logic                          last,
	output logic                          empty_res
);

	localparam int N = topk_pkg::MAX_KEEP;

	topk_pkg::state_t        state_q;
	topk_pkg::fill_t         fill_q;
	topk_pkg::fill_t         remain_q;
	logic [topk_pkg::CFG_W-1:0] keep_count_q;
	topk_pkg::fill_t         k_eff;
	topk_pkg::fill_t         emit_n;
	topk_pkg::cell_op_t      op;
	logic                    accept;
	logic                    hit_any;

	logic                    result_strobe_q;
	topk_pkg::data_t         result_id_q;
	logic                    last_q;
	logic                    empty_res_q;

	topk_pkg::link_t         links [N];
	topk_pkg::link_t         lefts [N];
	topk_pkg::link_t         rights [N];
	logic [N-1:0]            hits;
	logic [N-1:0]            valid_vec;

	assign busy   = (state_q == topk_pkg::ST_FLUSH);
	assign accept = start && !busy;

	always_comb begin
		if (keep_count_q == '0) begin
			k_eff = topk_pkg::FILL_W'(1);
		end else if (int'(keep_count_q) > N) begin
			k_eff = topk_pkg::FILL_W'(N);
		end else begin
			k_eff = topk_pkg::FILL_W'(keep_count_q);
		end
	end

	assign emit_n  = (fill_q < k_eff) ? fill_q : k_eff;
	assign hit_any = |hits;

	always_comb begin
		op = topk_pkg::OP_HOLD;
		if (busy) begin
			op = (remain_q == topk_pkg::FILL_W'(1)) ? topk_pkg::OP_CLEAR : topk_pkg::OP_SHIFT;
		end else if (accept && !func) begin
			if (fill_q < k_eff) begin
				op = topk_pkg::OP_ADD;
			end else if (fill_q != '0 && hit_any) begin
				op = topk_pkg::OP_REPLACE;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign lefts[gi] = '{valid: 1'b1, ahead: 1'b0, held_dist: '0, id: '0};
			end else begin : g_mid
				assign lefts[gi] = links[gi-1];
			end
			if (gi == N - 1) begin : g_tail
				assign rights[gi] = '{valid: 1'b0, ahead: 1'b0, held_dist: '0, id: '0};
			end else begin : g_body
				assign rights[gi] = links[gi+1];
			end
			assign valid_vec[gi] = links[gi].valid;

			topk_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (op),
				.new_dist (distance),
				.new_id   (cand_id),
				.left     (lefts[gi]),
				.right    (rights[gi]),
				.link     (links[gi]),
				.hit      (hits[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= topk_pkg::ST_IDLE;
			fill_q          <= '0;
			remain_q        <= '0;
			keep_count_q    <= topk_pkg::KEEP_RESET;
			result_strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_count_q <= cfg_wdata;
			end
			result_strobe_q <= 1'b0;
			unique case (state_q)
				topk_pkg::ST_IDLE: begin
					if (op == topk_pkg::OP_ADD) begin
						fill_q <= fill_q + topk_pkg::FILL_W'(1);
					end
					if (accept && func) begin
						if (fill_q == '0) begin
							result_strobe_q <= 1'b1;
						end else begin
							remain_q <= emit_n;
							state_q  <= topk_pkg::ST_FLUSH;
						end
					end
				end
				topk_pkg::ST_FLUSH: begin
					result_strobe_q <= 1'b1;
					remain_q        <= remain_q - topk_pkg::FILL_W'(1);
					if (remain_q == topk_pkg::FILL_W'(1)) begin
						fill_q  <= '0;
						state_q <= topk_pkg::ST_IDLE;
					end
				end
				default: state_q <= topk_pkg::ST_IDLE;
			endcase
		end
	end

	// Result payload; the strobe alone marks a beat.
	always_ff @(posedge clk) begin
		if (busy) begin
			result_id_q <= links[0].id;
			last_q      <= (remain_q == topk_pkg::FILL_W'(1));
			empty_res_q <= 1'b0;
		end else if (accept && func) begin
			result_id_q <= '0;
			last_q      <= 1'b1;
			empty_res_q <= 1'b1;
		end
	end

	assign result_strobe = result_strobe_q;
	assign result_id     = result_id_q;
	assign last          = last_q;
	assign empty_res     = empty_res_q;

	// Outside a flush the valid cells match the count; a flush drains them first.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(valid_vec) == int'(fill_q)))
		else $error("cell valid bits disagree with fill count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + N'(1))) == '0)
		else $error("held entries are not contiguous from cell 0");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (fill_q != '0 && remain_q != '0 && remain_q <= fill_q))
		else $error("flush running with nothing to emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && empty_res) |-> (last && !busy))
		else $error("empty flush result not marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |-> (!busy && fill_q == '0))
		else $error("store not cleared after last result");

endmodule

`default_nettype wire

// ===== hdl/topk_cell.sv =====
// One cell of the sorted candidate chain: holds a distance, an id and a valid bit.
// Depends on topk_pkg for the link struct, the op codes and the pair compare.
`default_nettype none

module topk_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  topk_pkg::cell_op_t  op,
	input  topk_pkg::data_t     new_dist,
	input  topk_pkg::data_t     new_id,
	input  topk_pkg::link_t     left,
	input  topk_pkg::link_t     right,
	output topk_pkg::link_t     link,
	output logic                hit
);

	logic            valid_q;
	topk_pkg::data_t dist_q;
	topk_pkg::data_t id_q;
	logic            ahead;
	logic            enable;
	logic            here;

	// The new pair sorts ahead of this held entry.
	assign ahead = valid_q && topk_pkg::pair_after(dist_q, id_q, new_dist, new_id);
	// This cell holds the worst entry of the chain and the new distance beats it.
	assign hit   = valid_q && !right.valid && (new_dist < dist_q);

	assign enable = (op == topk_pkg::OP_ADD) || valid_q;
	assign here   = ahead || !valid_q;

	assign link.valid     = valid_q;
	assign link.ahead     = ahead;
	assign link.held_dist = dist_q;
	assign link.id        = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op) inside
				topk_pkg::OP_ADD, topk_pkg::OP_REPLACE: begin
					if (enable && here && left.valid) begin
						valid_q <= 1'b1;
					end
				end
				topk_pkg::OP_SHIFT: valid_q <= right.valid;
				topk_pkg::OP_CLEAR: valid_q <= 1'b0;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op) inside
			topk_pkg::OP_ADD, topk_pkg::OP_REPLACE: begin
				if (enable && here && left.valid) begin
					if (left.ahead) begin
						dist_q <= left.held_dist;
						id_q   <= left.id;
					end else begin
						dist_q <= new_dist;
						id_q   <= new_id;
					end
				end
			end
			topk_pkg::OP_SHIFT: begin
				dist_q <= right.held_dist;
				id_q   <= right.id;
			end
			default: begin
				dist_q <= dist_q;
				id_q   <= id_q;
			end
		endcase
	end

endmodule

`default_nettype wire
